>>> rtl/tfrg_pkg.sv
// ---------------------------------------------------------------------------
// tfrg_pkg: shared types, constants and mixing functions
// Holds the controller states and the three shuffle functions of the
// table-feedback random generator.
// ---------------------------------------------------------------------------
package tfrg_pkg;

  localparam int unsigned WORD_W = 64;

  localparam logic [WORD_W-1:0] FILL_CONST = 64'd12463423;
  localparam logic [WORD_W-1:0] MIX_CONST  = 64'd9263354725;

  typedef logic [WORD_W-1:0] word_t;

  // Operation codes of an input beat
  typedef enum logic {
    OP_RESEED = 1'b0,
    OP_DRAW   = 1'b1
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_FILL
  } state_t;

  // Seed the first table entry
  function automatic word_t fill_start(input word_t s);
    return s ^ ((s << 30) | FILL_CONST);
  endfunction

  // Derive the next table entry during a refill
  function automatic word_t shuffle1(input word_t a);
    word_t na;
    na = ~a;
    return (a >> 19) ^ (a >> 2) ^ (na << 24) ^ na;
  endfunction

  // Replace a table entry on a draw
  function automatic word_t shuffle2(input word_t a, input word_t b);
    word_t na;
    word_t nb;
    na = ~a;
    nb = ~b;
    return (nb << 36) ^ (nb >> 6) ^ (nb << 43) ^ (na >> 34) ^ a
      ^ (na << 4) ^ MIX_CONST;
  endfunction

  // Fold a new entry into the running seed
  function automatic word_t shuffle3(input word_t a);
    word_t na;
    na = ~a;
    return (na << 42) ^ (na & MIX_CONST) ^ (na << 17) ^ (na >> 34)
      ^ (na << 4);
  endfunction

endpackage

>>> rtl/table_feedback_random_generator.sv
// ---------------------------------------------------------------------------
// table_feedback_random_generator
// 64-bit pseudo-random generator with a feedback table held in one
// synchronous single-port-read memory.
// ---------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. A draw keeps busy high
// in ST_DRAW: the pointed table word is read from the memory at the accept
// edge, then mixed, written back and folded into the seed in the next cycle;
// random_value appears with done high for one cycle right after, and the
// receiver cannot hold it off. The next beat can be taken in that done cycle,
// so a new draw can be accepted while the last result is being shown.
// A reseed returns nothing and keeps busy high in ST_FILL while the refill
// writes one table word a cycle through the memory write port and the pointer
// (seed mod TABLE_DEPTH) is reduced sixteen seed bits a cycle with a
// reciprocal multiply. After reset a clearing pass zeroes the table, one word
// a cycle, with busy held high.
// ---------------------------------------------------------------------------
module table_feedback_random_generator #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [63:0] seed_value,
  output logic        done,
  output logic [63:0] random_value
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DG = 16;
  localparam int unsigned BW = 3;
  localparam int unsigned VW = AW + DG;
  localparam int unsigned MW = AW + DG + 1;
  localparam int unsigned SH = 2 * AW + DG;
  localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
  localparam logic [AW:0]   DEPTH_R  = (AW + 1)'(TABLE_DEPTH);
  localparam logic [BW-1:0] DIGITS_C = BW'(tfrg_pkg::WORD_W / DG);
  // ceil(2^SH / TABLE_DEPTH): exact quotient for every partial remainder
  localparam logic [63:0]   RECIP_FULL =
    ((64'd1 << SH) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
  localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

  // Table memory
  tfrg_pkg::word_t mix_table [TABLE_DEPTH];
  tfrg_pkg::word_t rd_data;

  tfrg_pkg::state_t state;
  tfrg_pkg::state_t state_next;

  tfrg_pkg::word_t  running_seed;
  tfrg_pkg::word_t  fill_word;
  tfrg_pkg::word_t  mod_shift;
  logic [AW-1:0]    table_pointer;
  logic [AW-1:0]    mod_rem;
  logic [CW-1:0]    fill_cnt;
  logic [BW-1:0]    digit_cnt;

  logic             accept;
  logic             fill_end;
  logic             mod_end;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  tfrg_pkg::word_t  mem_wdata;
  tfrg_pkg::word_t  draw_entry;
  logic [AW-1:0]    pointer_inc;
  logic [VW-1:0]    mod_val;
  logic [VW+MW-1:0] mod_prod;
  logic [DG-1:0]    mod_quo;
  logic [AW-1:0]    mod_rem_next;

  assign accept   = start && !busy;
  assign fill_end = (fill_cnt == DEPTH_C);
  assign mod_end  = (digit_cnt == DIGITS_C);

  // Mix the word read at the pointer
  assign draw_entry = tfrg_pkg::shuffle2(rd_data, running_seed);

  // Advance the pointer with wrap
  assign pointer_inc = (table_pointer == AW'(TABLE_DEPTH - 1)) ? '0 : table_pointer + 1'b1;

  // Take one 16-bit seed digit into the remainder
  assign mod_val      = {mod_rem, mod_shift[tfrg_pkg::WORD_W-1 -: DG]};
  assign mod_prod     = mod_val * RECIP;
  assign mod_quo      = mod_prod[SH +: DG];
  assign mod_rem_next = AW'(mod_val - VW'(mod_quo) * VW'(DEPTH_R));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tfrg_pkg::ST_CLEAR: begin
        if (fill_end) state_next = tfrg_pkg::ST_IDLE;
      end
      tfrg_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (op == tfrg_pkg::OP_DRAW) ? tfrg_pkg::ST_DRAW : tfrg_pkg::ST_FILL;
        end
      end
      tfrg_pkg::ST_DRAW: begin
        state_next = tfrg_pkg::ST_IDLE;
      end
      tfrg_pkg::ST_FILL: begin
        if (fill_end && mod_end) state_next = tfrg_pkg::ST_IDLE;
      end
      default: state_next = tfrg_pkg::ST_CLEAR;
    endcase
  end

  // Outputs and memory write controls
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = fill_cnt[AW-1:0];
    mem_wdata = fill_word;
    case (state)
      tfrg_pkg::ST_CLEAR,
      tfrg_pkg::ST_FILL: begin
        mem_we = !fill_end;
      end
      tfrg_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      tfrg_pkg::ST_DRAW: begin
        mem_we    = 1'b1;
        mem_waddr = table_pointer;
        mem_wdata = draw_entry;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Write and read the table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mix_table[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= mix_table[table_pointer];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tfrg_pkg::ST_CLEAR;
      fill_cnt      <= '0;
      digit_cnt     <= '0;
      table_pointer <= '0;
      running_seed  <= '0;
      fill_word     <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == tfrg_pkg::ST_DRAW);
      case (state)
        tfrg_pkg::ST_CLEAR: begin
          if (!fill_end) fill_cnt <= fill_cnt + 1'b1;
        end
        tfrg_pkg::ST_IDLE: begin
          if (accept && (op == tfrg_pkg::OP_RESEED)) begin
            running_seed <= seed_value;
            fill_word    <= tfrg_pkg::fill_start(seed_value);
            fill_cnt     <= '0;
            digit_cnt    <= '0;
          end
        end
        tfrg_pkg::ST_DRAW: begin
          running_seed  <= running_seed ^ tfrg_pkg::shuffle3(draw_entry);
          table_pointer <= pointer_inc;
        end
        tfrg_pkg::ST_FILL: begin
          if (!fill_end) begin
            fill_cnt  <= fill_cnt + 1'b1;
            fill_word <= tfrg_pkg::shuffle1(fill_word);
          end
          if (!mod_end) digit_cnt <= digit_cnt + 1'b1;
          if (fill_end && mod_end) table_pointer <= mod_rem;
        end
        default: begin
          fill_cnt <= '0;
        end
      endcase
    end
  end

  // Remainder datapath and result register
  always_ff @(posedge clk) begin
    if (accept && (op == tfrg_pkg::OP_RESEED)) begin
      mod_shift <= seed_value;
      mod_rem   <= '0;
    end else if ((state == tfrg_pkg::ST_FILL) && !mod_end) begin
      mod_shift <= mod_shift << DG;
      mod_rem   <= mod_rem_next;
    end
    if (state == tfrg_pkg::ST_DRAW) begin
      random_value <= running_seed ^ tfrg_pkg::shuffle3(draw_entry);
    end
  end

endmodule
